[rtl/cmos6502_instruction_predecoder_macros.svh]
// Assertion macros for the 65C02 instruction predecoder.
// No dependencies; included by the top level only.
`ifndef CMOS6502_INSTRUCTION_PREDECODER_MACROS_SVH
`define CMOS6502_INSTRUCTION_PREDECODER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define C65PD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("predecoder check failed");

// next-cycle implication, checked while out of reset
`define C65PD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("predecoder check failed");

`endif

[rtl/c65pd_pkg.sv]
// Package for the 65C02 instruction predecoder: types, codes, opcode table.
// No dependencies.
package c65pd_pkg;

  typedef enum logic [3:0] {
    AM_IMP = 4'd0,
    AM_ACC = 4'd1,
    AM_IMM = 4'd2,
    AM_ZP  = 4'd3,
    AM_ZPX = 4'd4,
    AM_ZPY = 4'd5,
    AM_ABS = 4'd6,
    AM_ABX = 4'd7,
    AM_ABY = 4'd8,
    AM_IND = 4'd9,
    AM_IZX = 4'd10,
    AM_IZY = 4'd11,
    AM_ZPI = 4'd12,
    AM_AIX = 4'd13,
    AM_REL = 4'd14
  } addr_mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_NONE    = 2'd2
  } status_e;

  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_JMP_ABS = 8'h4c;
  localparam logic [15:0] REL_BIAS  = 16'd2;

  typedef struct packed {
    logic       known;
    logic [6:0] mnem;
    addr_mode_e mode;
  } op_entry_t;

  // decode results handed from the decoder to the operand/target stage
  typedef struct packed {
    status_e    status;
    logic [6:0] mnem;
    addr_mode_e mode;
    logic [1:0] len;
    logic       is_jump;
  } dec_t;

  function automatic op_entry_t mk(input logic [6:0] m, input addr_mode_e md);
    op_entry_t e;
    e.known = 1'b1;
    e.mnem  = m;
    e.mode  = md;
    return e;
  endfunction

  function automatic logic [1:0] mode_length(input addr_mode_e md);
    logic [1:0] len;
    unique case (md)
      AM_IMP, AM_ACC:                         len = 2'd1;
      AM_ABS, AM_ABX, AM_ABY, AM_IND, AM_AIX: len = 2'd3;
      default:                                len = 2'd2;
    endcase
    return len;
  endfunction

  function automatic op_entry_t op_lookup(input logic [7:0] op);
    op_entry_t e;
    unique case (op)
      8'h00: e = mk(7'd0, AM_IMP);   8'h01: e = mk(7'd1, AM_IZX);
      8'h04: e = mk(7'd2, AM_ZP);    8'h05: e = mk(7'd1, AM_ZP);
      8'h06: e = mk(7'd3, AM_ZP);    8'h08: e = mk(7'd4, AM_IMP);
      8'h09: e = mk(7'd1, AM_IMM);   8'h0a: e = mk(7'd3, AM_ACC);
      8'h0c: e = mk(7'd2, AM_ABS);   8'h0d: e = mk(7'd1, AM_ABS);
      8'h0e: e = mk(7'd3, AM_ABS);   8'h10: e = mk(7'd5, AM_REL);
      8'h11: e = mk(7'd1, AM_IZY);   8'h12: e = mk(7'd1, AM_ZPI);
      8'h14: e = mk(7'd6, AM_ZP);    8'h15: e = mk(7'd1, AM_ZPX);
      8'h16: e = mk(7'd3, AM_ZPX);   8'h18: e = mk(7'd7, AM_IMP);
      8'h19: e = mk(7'd1, AM_ABY);   8'h1a: e = mk(7'd8, AM_ACC);
      8'h1c: e = mk(7'd6, AM_ABS);   8'h1d: e = mk(7'd1, AM_ABX);
      8'h1e: e = mk(7'd3, AM_ABX);   8'h20: e = mk(7'd9, AM_ABS);
      8'h21: e = mk(7'd10, AM_IZX);  8'h24: e = mk(7'd11, AM_ZP);
      8'h25: e = mk(7'd10, AM_ZP);   8'h26: e = mk(7'd12, AM_ZP);
      8'h28: e = mk(7'd13, AM_IMP);  8'h29: e = mk(7'd10, AM_IMM);
      8'h2a: e = mk(7'd12, AM_ACC);  8'h2c: e = mk(7'd11, AM_ABS);
      8'h2d: e = mk(7'd10, AM_ABS);  8'h2e: e = mk(7'd12, AM_ABS);
      8'h30: e = mk(7'd14, AM_REL);  8'h31: e = mk(7'd10, AM_IZY);
      8'h32: e = mk(7'd10, AM_ZPI);  8'h34: e = mk(7'd11, AM_ZPX);
      8'h35: e = mk(7'd10, AM_ZPX);  8'h36: e = mk(7'd12, AM_ZPX);
      8'h38: e = mk(7'd15, AM_IMP);  8'h39: e = mk(7'd10, AM_ABY);
      8'h3a: e = mk(7'd16, AM_ACC);  8'h3c: e = mk(7'd11, AM_ABX);
      8'h3d: e = mk(7'd10, AM_ABX);  8'h3e: e = mk(7'd12, AM_ABX);
      8'h40: e = mk(7'd17, AM_IMP);  8'h41: e = mk(7'd18, AM_IZX);
      8'h45: e = mk(7'd18, AM_ZP);   8'h46: e = mk(7'd19, AM_ZP);
      8'h48: e = mk(7'd20, AM_IMP);  8'h49: e = mk(7'd18, AM_IMM);
      8'h4a: e = mk(7'd19, AM_ACC);  8'h4c: e = mk(7'd21, AM_ABS);
      8'h4d: e = mk(7'd18, AM_ABS);  8'h4e: e = mk(7'd19, AM_ABS);
      8'h50: e = mk(7'd22, AM_REL);  8'h51: e = mk(7'd18, AM_IZY);
      8'h52: e = mk(7'd18, AM_ZPI);  8'h55: e = mk(7'd18, AM_ZPX);
      8'h56: e = mk(7'd19, AM_ZPX);  8'h58: e = mk(7'd23, AM_IMP);
      8'h59: e = mk(7'd18, AM_ABY);  8'h5a: e = mk(7'd24, AM_IMP);
      8'h5d: e = mk(7'd18, AM_ABX);  8'h5e: e = mk(7'd19, AM_ABX);
      8'h60: e = mk(7'd25, AM_IMP);  8'h61: e = mk(7'd26, AM_IZX);
      8'h64: e = mk(7'd27, AM_ZP);   8'h65: e = mk(7'd26, AM_ZP);
      8'h66: e = mk(7'd28, AM_ZP);   8'h68: e = mk(7'd29, AM_IMP);
      8'h69: e = mk(7'd26, AM_IMM);  8'h6a: e = mk(7'd28, AM_ACC);
      8'h6c: e = mk(7'd21, AM_IND);  8'h6d: e = mk(7'd26, AM_ABS);
      8'h6e: e = mk(7'd28, AM_ABS);  8'h70: e = mk(7'd30, AM_REL);
      8'h71: e = mk(7'd26, AM_IZY);  8'h72: e = mk(7'd26, AM_ZPI);
      8'h74: e = mk(7'd27, AM_ZPX);  8'h75: e = mk(7'd26, AM_ZPX);
      8'h76: e = mk(7'd28, AM_ZPX);  8'h78: e = mk(7'd31, AM_IMP);
      8'h79: e = mk(7'd26, AM_ABY);  8'h7a: e = mk(7'd32, AM_IMP);
      8'h7c: e = mk(7'd21, AM_AIX);  8'h7d: e = mk(7'd26, AM_ABX);
      8'h7e: e = mk(7'd28, AM_ABX);  8'h80: e = mk(7'd33, AM_REL);
      8'h81: e = mk(7'd34, AM_IZX);  8'h84: e = mk(7'd35, AM_ZP);
      8'h85: e = mk(7'd34, AM_ZP);   8'h86: e = mk(7'd36, AM_ZP);
      8'h88: e = mk(7'd37, AM_IMP);  8'h89: e = mk(7'd11, AM_IMM);
      8'h8a: e = mk(7'd38, AM_IMP);  8'h8c: e = mk(7'd35, AM_ABS);
      8'h8d: e = mk(7'd34, AM_ABS);  8'h8e: e = mk(7'd36, AM_ABS);
      8'h90: e = mk(7'd39, AM_REL);  8'h91: e = mk(7'd34, AM_IZY);
      8'h92: e = mk(7'd34, AM_ZPI);  8'h94: e = mk(7'd35, AM_ZPX);
      8'h95: e = mk(7'd34, AM_ZPX);  8'h96: e = mk(7'd36, AM_ZPY);
      8'h98: e = mk(7'd40, AM_IMP);  8'h99: e = mk(7'd34, AM_ABY);
      8'h9a: e = mk(7'd41, AM_IMP);  8'h9c: e = mk(7'd27, AM_ABS);
      8'h9d: e = mk(7'd34, AM_ABX);  8'h9e: e = mk(7'd27, AM_ABX);
      8'ha0: e = mk(7'd42, AM_IMM);  8'ha1: e = mk(7'd43, AM_IZX);
      8'ha2: e = mk(7'd44, AM_IMM);  8'ha4: e = mk(7'd42, AM_ZP);
      8'ha5: e = mk(7'd43, AM_ZP);   8'ha6: e = mk(7'd44, AM_ZP);
      8'ha8: e = mk(7'd45, AM_IMP);  8'ha9: e = mk(7'd43, AM_IMM);
      8'haa: e = mk(7'd46, AM_IMP);  8'hac: e = mk(7'd42, AM_ABS);
      8'had: e = mk(7'd43, AM_ABS);  8'hae: e = mk(7'd44, AM_ABS);
      8'hb0: e = mk(7'd47, AM_REL);  8'hb1: e = mk(7'd43, AM_IZY);
      8'hb2: e = mk(7'd43, AM_ZPI);  8'hb4: e = mk(7'd42, AM_ZPX);
      8'hb5: e = mk(7'd43, AM_ZPX);  8'hb6: e = mk(7'd44, AM_ZPY);
      8'hb8: e = mk(7'd48, AM_IMP);  8'hb9: e = mk(7'd43, AM_ABY);
      8'hba: e = mk(7'd49, AM_IMP);  8'hbc: e = mk(7'd42, AM_ABX);
      8'hbd: e = mk(7'd43, AM_ABX);  8'hbe: e = mk(7'd44, AM_ABY);
      8'hc0: e = mk(7'd50, AM_IMM);  8'hc1: e = mk(7'd51, AM_IZX);
      8'hc4: e = mk(7'd50, AM_ZP);   8'hc5: e = mk(7'd51, AM_ZP);
      8'hc6: e = mk(7'd16, AM_ZP);   8'hc8: e = mk(7'd52, AM_IMP);
      8'hc9: e = mk(7'd51, AM_IMM);  8'hca: e = mk(7'd53, AM_IMP);
      8'hcb: e = mk(7'd54, AM_IMP);  8'hcc: e = mk(7'd50, AM_ABS);
      8'hcd: e = mk(7'd51, AM_ABS);  8'hce: e = mk(7'd16, AM_ABS);
      8'hd0: e = mk(7'd55, AM_REL);  8'hd1: e = mk(7'd51, AM_IZY);
      8'hd2: e = mk(7'd51, AM_ZPI);  8'hd5: e = mk(7'd51, AM_ZPX);
      8'hd6: e = mk(7'd16, AM_ZPX);  8'hd8: e = mk(7'd56, AM_IMP);
      8'hd9: e = mk(7'd51, AM_ABY);  8'hda: e = mk(7'd57, AM_IMP);
      8'hdb: e = mk(7'd58, AM_IMP);  8'hdd: e = mk(7'd51, AM_ABX);
      8'hde: e = mk(7'd16, AM_ABX);  8'he0: e = mk(7'd59, AM_IMM);
      8'he1: e = mk(7'd60, AM_IZX);  8'he4: e = mk(7'd59, AM_ZP);
      8'he5: e = mk(7'd60, AM_ZP);   8'he6: e = mk(7'd8, AM_ZP);
      8'he8: e = mk(7'd61, AM_IMP);  8'he9: e = mk(7'd60, AM_IMM);
      8'hea: e = mk(7'd62, AM_IMP);  8'hec: e = mk(7'd59, AM_ABS);
      8'hed: e = mk(7'd60, AM_ABS);  8'hee: e = mk(7'd8, AM_ABS);
      8'hf0: e = mk(7'd63, AM_REL);  8'hf1: e = mk(7'd60, AM_IZY);
      8'hf2: e = mk(7'd60, AM_ZPI);  8'hf5: e = mk(7'd60, AM_ZPX);
      8'hf6: e = mk(7'd8, AM_ZPX);   8'hf8: e = mk(7'd64, AM_IMP);
      8'hf9: e = mk(7'd60, AM_ABY);  8'hfa: e = mk(7'd65, AM_IMP);
      8'hfd: e = mk(7'd60, AM_ABX);  8'hfe: e = mk(7'd8, AM_ABX);
      default: begin
        e.known = 1'b0;
        e.mnem  = 7'd0;
        e.mode  = AM_IMP;
      end
    endcase
    return e;
  endfunction

endpackage

[rtl/c65pd_decode.sv]
// Opcode decode: table lookup, length and status against available bytes.
// Depends on c65pd_pkg.
module c65pd_decode (
  input  logic [7:0]      opcode_byte_i,
  input  logic [1:0]      bytes_available_i,
  output c65pd_pkg::dec_t dec_o
);

  c65pd_pkg::op_entry_t entry;
  logic [1:0]           len;

  assign entry = c65pd_pkg::op_lookup(opcode_byte_i);
  assign len   = c65pd_pkg::mode_length(entry.mode);

  always_comb begin
    dec_o.status  = c65pd_pkg::STAT_OK;
    dec_o.mnem    = entry.mnem;
    dec_o.mode    = entry.mode;
    dec_o.len     = len;
    dec_o.is_jump = (entry.mode == c65pd_pkg::AM_ABS) &&
                    ((opcode_byte_i == c65pd_pkg::OP_JSR) ||
                     (opcode_byte_i == c65pd_pkg::OP_JMP_ABS));
    if (bytes_available_i == 2'd0) begin
      dec_o.status  = c65pd_pkg::STAT_NONE;
      dec_o.mnem    = 7'd0;
      dec_o.mode    = c65pd_pkg::AM_IMP;
      dec_o.len     = 2'd0;
      dec_o.is_jump = 1'b0;
    end else if (!entry.known || (bytes_available_i < len)) begin
      // unknown or truncated: one byte consumed
      dec_o.status  = c65pd_pkg::STAT_UNKNOWN;
      dec_o.mnem    = 7'd0;
      dec_o.mode    = c65pd_pkg::AM_IMP;
      dec_o.len     = 2'd1;
      dec_o.is_jump = 1'b0;
    end
  end

endmodule

[rtl/c65pd_target.sv]
// Operand assembly and control-flow target computation.
// Depends on c65pd_pkg.
module c65pd_target (
  input  c65pd_pkg::dec_t dec_i,
  input  logic [7:0]      operand_low_i,
  input  logic [7:0]      operand_high_i,
  input  logic [15:0]     pc_address_i,
  output logic [15:0]     operand_value_o,
  output logic            has_target_o,
  output logic [15:0]     target_address_o
);

  logic        ok;
  logic        is_rel;
  logic [15:0] rel_target;

  assign ok     = (dec_i.status == c65pd_pkg::STAT_OK);
  assign is_rel = ok && (dec_i.mode == c65pd_pkg::AM_REL);

  // wraps to 16 bits
  assign rel_target = pc_address_i + c65pd_pkg::REL_BIAS +
                      {{8{operand_low_i[7]}}, operand_low_i};

  always_comb begin
    operand_value_o = 16'd0;
    if (ok && (dec_i.len == 2'd2)) begin
      operand_value_o = {8'd0, operand_low_i};
    end else if (ok && (dec_i.len == 2'd3)) begin
      operand_value_o = {operand_high_i, operand_low_i};
    end
  end

  always_comb begin
    has_target_o     = 1'b0;
    target_address_o = 16'd0;
    if (is_rel) begin
      has_target_o     = 1'b1;
      target_address_o = rel_target;
    end else if (ok && dec_i.is_jump) begin
      has_target_o     = 1'b1;
      target_address_o = operand_value_o;
    end
  end

endmodule

[rtl/cmos6502_instruction_predecoder.sv]
// 65C02 instruction predecoder, top level: input register, decode, result register.
// Depends on c65pd_pkg, c65pd_decode, c65pd_target and the assertion macros header.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with opcode, two operand bytes, the
//   count of valid bytes and the opcode address. A beat is taken on a rising
//   edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i with status, mnemonic index,
//   addressing mode, length, operand and branch/jump target.
// Pipeline: a beat is registered in the input register, decoded combinationally and
//   its result is captured in the result register (two register stages).
// Throughput: one beat per clock while out_stall_i is low; the decode table and
//   the 16-bit target adder sit between the input and result registers.
// Stall: a result held under out_stall_i stays put; one more beat can still
//   be taken into the input register, after which in_stall_o rises until the
//   result is taken.
// Reset: rst_ni clears both valid flags; no results are pending afterward.
`include "cmos6502_instruction_predecoder_macros.svh"

module cmos6502_instruction_predecoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  opcode_byte_i,
  input  logic [7:0]  operand_low_i,
  input  logic [7:0]  operand_high_i,
  input  logic [1:0]  bytes_available_i,
  input  logic [15:0] pc_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  mnemonic_index_o,
  output logic [3:0]  address_mode_o,
  output logic [1:0]  instr_length_o,
  output logic [15:0] operand_value_o,
  output logic        has_target_o,
  output logic [15:0] target_address_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  op_q, lo_q, hi_q;
  logic [1:0]  avail_q;
  logic [15:0] pc_q;
  logic        in_take;
  logic        advance;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q;
  logic [6:0]  mnem_q;
  logic [3:0]  mode_q;
  logic [1:0]  len_q;
  logic [15:0] operand_q, target_q;
  logic        has_target_q;

  c65pd_pkg::dec_t dec;
  logic [15:0]     operand;
  logic            has_target;
  logic [15:0]     target;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= opcode_byte_i;
      lo_q    <= operand_low_i;
      hi_q    <= operand_high_i;
      avail_q <= bytes_available_i;
      pc_q    <= pc_address_i;
    end
  end

  c65pd_decode u_decode (
    .opcode_byte_i     (op_q),
    .bytes_available_i (avail_q),
    .dec_o             (dec)
  );

  c65pd_target u_target (
    .dec_i            (dec),
    .operand_low_i    (lo_q),
    .operand_high_i   (hi_q),
    .pc_address_i     (pc_q),
    .operand_value_o  (operand),
    .has_target_o     (has_target),
    .target_address_o (target)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q     <= dec.status;
      mnem_q       <= dec.mnem;
      mode_q       <= dec.mode;
      len_q        <= dec.len;
      operand_q    <= operand;
      has_target_q <= has_target;
      target_q     <= target;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign mnemonic_index_o = mnem_q;
  assign address_mode_o   = mode_q;
  assign instr_length_o   = len_q;
  assign operand_value_o  = operand_q;
  assign has_target_o     = has_target_q;
  assign target_address_o = target_q;

  `C65PD_ASSERT_NOW(a_none_empty, clk_i, rst_ni,
    out_valid_o && (status_o == c65pd_pkg::STAT_NONE),
    (instr_length_o == 2'd0) && !has_target_o && (operand_value_o == 16'd0))
  `C65PD_ASSERT_NOW(a_unknown_len1, clk_i, rst_ni,
    out_valid_o && (status_o == c65pd_pkg::STAT_UNKNOWN),
    (instr_length_o == 2'd1) && !has_target_o && (mnemonic_index_o == 7'd0))
  `C65PD_ASSERT_NOW(a_target_ok, clk_i, rst_ni,
    out_valid_o && has_target_o, status_o == c65pd_pkg::STAT_OK)
  `C65PD_ASSERT_NEXT(a_stall_holds_item, clk_i, rst_ni,
    in_stall_o, in_valid_q && out_valid_q)

endmodule
